// ===== src/qtlc_pkg.sv =====
package qtlc_pkg;

	// Coordinate format of the corners: signed fixed point, 4 fraction bits.
	localparam int COORD_W   = 24;
	localparam int FRAC_BITS = 4;

	// Width of the area limit in fixed point (max_quad_size * 16).
	localparam int SIZE_W = 16;
	localparam int LIM_W  = SIZE_W + FRAC_BITS;

	// Absolute extent of one axis, one bit wider than a coordinate.
	localparam int EXT_W = COORD_W + 1;

	// Cell count after rounding the extent up to whole units.
	localparam int NEED_W = EXT_W + 1 - FRAC_BITS;

	// Result fields.
	localparam int CODE_W  = 31;
	localparam int DEPTH_W = 4;
	localparam int SHIFT_W = 5;

	// Number of corners, one lane each.
	localparam int NUM_CORNERS = 4;

	// Corner order on the lanes.
	localparam int CORNER_BL = 0;
	localparam int CORNER_TL = 1;
	localparam int CORNER_BR = 2;
	localparam int CORNER_TR = 3;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MAX_QUAD_SIZE = 1'b0;
	localparam logic [SIZE_W-1:0] MAX_QUAD_SIZE_RESET = 16'h8000;

	// What one lane reports about its corner.
	typedef struct packed {
		logic               bad;   // corner outside the quad area
		logic               high;  // corner beyond the reach of the deepest code
		logic [COORD_W-1:0] diff;  // bits in which the corner differs from bottom-left
	} lane_info_t;

	// Depth decision handed to the encoder stage.
	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [SHIFT_W-1:0] shift;
	} depth_info_t;

endpackage

// ===== src/quadtree_location_code.sv =====
// Linear-quadtree locational code of the smallest cell that holds a quad.
// Input channel (in_valid/in_stall) carries the four corners of one quad in
// quad space, signed fixed point with 4 fraction bits. Output channel
// (out_valid/out_stall) carries location_code, tree_depth and out_of_range.
// A transaction completes at a rising edge where valid is high and stall low.
// An input transaction loads the lane stage; the quad then moves on to the
// depth stage and then to the output register, which drives out_valid.
// Throughput is one quad per cycle while the receiver does not stall:
// four corner lanes run side by side and each stage holds one quad.
// When the receiver stalls, the result holds in the output register and
// earlier stages keep filling until no slot is free; only then in_stall
// rises. max_quad_size sits at byte address 0 of the APB port; the user
// must write it only while the block is idle; the block does not enforce it.
// Reset (arst_n low) empties the pipeline and sets max_quad_size to 32768.
module quadtree_location_code #(
	parameter int MAX_LEVEL = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [qtlc_pkg::COORD_W-1:0]  bl_x,
	input  logic signed [qtlc_pkg::COORD_W-1:0]  bl_y,
	input  logic signed [qtlc_pkg::COORD_W-1:0]  tl_x,
	input  logic signed [qtlc_pkg::COORD_W-1:0]  tl_y,
	input  logic signed [qtlc_pkg::COORD_W-1:0]  br_x,
	input  logic signed [qtlc_pkg::COORD_W-1:0]  br_y,
	input  logic signed [qtlc_pkg::COORD_W-1:0]  tr_x,
	input  logic signed [qtlc_pkg::COORD_W-1:0]  tr_y,
	// Output channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic        [qtlc_pkg::CODE_W-1:0]   location_code,
	output logic        [qtlc_pkg::DEPTH_W-1:0]  tree_depth,
	output logic                                 out_of_range,
	// Configuration port.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic        [qtlc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic        [qtlc_pkg::APB_DATA_W-1:0] pwdata,
	output logic        [qtlc_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);
	import qtlc_pkg::*;

	logic [SIZE_W-1:0] max_quad_size_q;
	logic [LIM_W-1:0]  lim;

	logic signed [COORD_W-1:0] corner_x [NUM_CORNERS];
	logic signed [COORD_W-1:0] corner_y [NUM_CORNERS];
	lane_info_t                info [NUM_CORNERS];

	logic               any_bad;
	logic               any_high;
	logic [COORD_W-1:0] all_diff;
	logic [EXT_W-1:0]   dx;
	logic [EXT_W-1:0]   dy;
	logic [EXT_W-1:0]   ext_x;
	logic [EXT_W-1:0]   ext_y;

	logic               en_s1;
	logic               en_s2;
	logic               en_out;

	logic               valid_s1;
	logic               bad_s1;
	logic               high_s1;
	logic [COORD_W-1:0] diff_s1;
	logic [EXT_W-1:0]   ext_x_s1;
	logic [EXT_W-1:0]   ext_y_s1;
	logic [COORD_W-1:0] bl_x_s1;
	logic [COORD_W-1:0] bl_y_s1;

	depth_info_t        dinfo;
	logic               valid_s2;
	logic               bad_s2;
	depth_info_t        dinfo_s2;
	logic [COORD_W-1:0] bl_x_s2;
	logic [COORD_W-1:0] bl_y_s2;

	logic [CODE_W-1:0]  code;
	logic               out_valid_q;
	logic [CODE_W-1:0]  location_code_q;
	logic [DEPTH_W-1:0] tree_depth_q;
	logic               out_of_range_q;

	// Configuration register: written in the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_quad_size_q <= MAX_QUAD_SIZE_RESET;
		end else if (psel && penable && pwrite && pready &&
				(paddr[APB_ADDR_W-1] == REG_MAX_QUAD_SIZE)) begin
			max_quad_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[APB_ADDR_W-1])
			REG_MAX_QUAD_SIZE: prdata = APB_DATA_W'(max_quad_size_q);
			default:           prdata = '0;
		endcase
	end

	assign lim = {max_quad_size_q, FRAC_BITS'(0)};

	// Stage enables: a stage moves when its next slot is free or moving.
	assign en_out   = !out_valid_q || !out_stall;
	assign en_s2    = !valid_s2 || en_out;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// One lane per corner, each compared against the bottom-left corner.
	assign corner_x[CORNER_BL] = bl_x;
	assign corner_y[CORNER_BL] = bl_y;
	assign corner_x[CORNER_TL] = tl_x;
	assign corner_y[CORNER_TL] = tl_y;
	assign corner_x[CORNER_BR] = br_x;
	assign corner_y[CORNER_BR] = br_y;
	assign corner_x[CORNER_TR] = tr_x;
	assign corner_y[CORNER_TR] = tr_y;

	for (genvar g = 0; g < NUM_CORNERS; g++) begin : g_lane
		qtlc_lane #(
			.MAX_LEVEL(MAX_LEVEL)
		) u_lane (
			.x     (corner_x[g]),
			.y     (corner_y[g]),
			.ref_x (bl_x),
			.ref_y (bl_y),
			.lim   (lim),
			.info  (info[g])
		);
	end

	// Merge the lane reports.
	always_comb begin
		any_bad  = 1'b0;
		any_high = 1'b0;
		all_diff = '0;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			any_bad  = any_bad  | info[i].bad;
			any_high = any_high | info[i].high;
			all_diff = all_diff | info[i].diff;
		end
	end

	// Extents: left edge along x, right edge along y.
	always_comb begin
		dx    = {tl_x[COORD_W-1], tl_x} - {bl_x[COORD_W-1], bl_x};
		dy    = {tr_y[COORD_W-1], tr_y} - {br_y[COORD_W-1], br_y};
		ext_x = dx[EXT_W-1] ? (~dx + EXT_W'(1)) : dx;
		ext_y = dy[EXT_W-1] ? (~dy + EXT_W'(1)) : dy;
	end

	// Stage 1: lane results and extents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			bad_s1   <= any_bad;
			high_s1  <= any_high;
			diff_s1  <= all_diff;
			ext_x_s1 <= ext_x;
			ext_y_s1 <= ext_y;
			bl_x_s1  <= $unsigned(bl_x);
			bl_y_s1  <= $unsigned(bl_y);
		end
	end

	qtlc_depth #(
		.MAX_LEVEL(MAX_LEVEL)
	) u_depth (
		.ext_x (ext_x_s1),
		.ext_y (ext_y_s1),
		.diff  (diff_s1),
		.high  (high_s1),
		.dinfo (dinfo)
	);

	// Stage 2: depth and shift of the enclosing cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			bad_s2   <= bad_s1;
			dinfo_s2 <= dinfo;
			bl_x_s2  <= bl_x_s1;
			bl_y_s2  <= bl_y_s1;
		end
	end

	qtlc_encode #(
		.MAX_LEVEL(MAX_LEVEL)
	) u_encode (
		.x     (bl_x_s2),
		.y     (bl_y_s2),
		.dinfo (dinfo_s2),
		.code  (code)
	);

	// Output register; a quad outside the area gives the root code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			if (bad_s2) begin
				location_code_q <= CODE_W'(1);
				tree_depth_q    <= '0;
				out_of_range_q  <= 1'b1;
			end else begin
				location_code_q <= code;
				tree_depth_q    <= dinfo_s2.depth;
				out_of_range_q  <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign location_code = location_code_q;
	assign tree_depth    = tree_depth_q;
	assign out_of_range  = out_of_range_q;

endmodule

// ===== src/qtlc_lane.sv =====
module qtlc_lane #(
	parameter int MAX_LEVEL = 15
) (
	input  logic signed [qtlc_pkg::COORD_W-1:0] x,
	input  logic signed [qtlc_pkg::COORD_W-1:0] y,
	input  logic signed [qtlc_pkg::COORD_W-1:0] ref_x,
	input  logic signed [qtlc_pkg::COORD_W-1:0] ref_y,
	input  logic        [qtlc_pkg::LIM_W-1:0]   lim,
	output qtlc_pkg::lane_info_t                info
);
	import qtlc_pkg::*;

	// Coordinates at or above this bit cannot be coded at any depth.
	localparam int TOP = FRAC_BITS + MAX_LEVEL;

	// A coordinate is outside when negative or above the limit.
	function automatic logic outside(input logic signed [COORD_W-1:0] c,
			input logic [LIM_W-1:0] l);
		return c[COORD_W-1] || (c[COORD_W-2:0] > (COORD_W-1)'(l));
	endfunction

	// A coordinate is too high when any bit from TOP upward is set.
	function automatic logic too_high(input logic signed [COORD_W-1:0] c);
		logic [COORD_W-1:0] u;
		u = $unsigned(c);
		return (u >> TOP) != '0;
	endfunction

	always_comb begin
		info.bad  = outside(x, lim) || outside(y, lim);
		info.high = too_high(x) || too_high(y);
		info.diff = $unsigned(x ^ ref_x) | $unsigned(y ^ ref_y);
	end

endmodule

// ===== src/qtlc_depth.sv =====
module qtlc_depth #(
	parameter int MAX_LEVEL = 15
) (
	input  logic [qtlc_pkg::EXT_W-1:0]   ext_x,
	input  logic [qtlc_pkg::EXT_W-1:0]   ext_y,
	input  logic [qtlc_pkg::COORD_W-1:0] diff,
	input  logic                         high,
	output qtlc_pkg::depth_info_t        dinfo
);
	import qtlc_pkg::*;

	localparam int TOP = FRAC_BITS + MAX_LEVEL;

	logic [EXT_W-1:0]   ext_max;
	logic [EXT_W:0]     ext_round;
	logic [NEED_W-1:0]  need;
	logic [DEPTH_W-1:0] layer;
	logic [SHIFT_W-1:0] diff_len;
	logic [SHIFT_W-1:0] shift_min;
	logic [SHIFT_W-1:0] shift;

	// Cells needed along the larger axis, rounded up to whole units.
	always_comb begin
		ext_max   = (ext_x > ext_y) ? ext_x : ext_y;
		ext_round = {1'b0, ext_max} + (EXT_W+1)'(15);
		need      = ext_round[EXT_W:FRAC_BITS];
	end

	// Smallest cell size that covers the extent, saturated at the top level.
	always_comb begin
		layer = DEPTH_W'(MAX_LEVEL);
		for (int i = MAX_LEVEL - 1; i >= 0; i--) begin
			if ((NEED_W'(1) << i) >= need) begin
				layer = DEPTH_W'(i);
			end
		end
	end

	// Bit length of the corner disagreement: the codes agree above it.
	always_comb begin
		diff_len = '0;
		for (int i = 0; i < COORD_W; i++) begin
			if (diff[i]) begin
				diff_len = SHIFT_W'(i + 1);
			end
		end
	end

	// Final shift is the coarser of the start layer and the agreement level.
	always_comb begin
		shift_min = SHIFT_W'(layer) + SHIFT_W'(FRAC_BITS);
		shift     = (diff_len > shift_min) ? diff_len : shift_min;
		dinfo.shift = shift;
		if (high || (shift >= SHIFT_W'(TOP))) begin
			dinfo.depth = '0;
		end else begin
			dinfo.depth = DEPTH_W'(SHIFT_W'(TOP) - shift);
		end
	end

endmodule

// ===== src/qtlc_encode.sv =====
module qtlc_encode #(
	parameter int MAX_LEVEL = 15
) (
	input  logic [qtlc_pkg::COORD_W-1:0] x,
	input  logic [qtlc_pkg::COORD_W-1:0] y,
	input  qtlc_pkg::depth_info_t        dinfo,
	output logic [qtlc_pkg::CODE_W-1:0]  code
);
	import qtlc_pkg::*;

	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;
	logic [CODE_W-1:0]  inter;
	logic [CODE_W-1:0]  marker;

	// Cell coordinates at the chosen depth, interleaved x in even bits.
	always_comb begin
		cell_x = x >> dinfo.shift;
		cell_y = y >> dinfo.shift;
		inter  = '0;
		for (int i = 0; i < MAX_LEVEL; i++) begin
			inter[2*i]   = cell_x[i];
			inter[2*i+1] = cell_y[i];
		end
	end

	// Keep the prefix below the marker and set the marker bit.
	always_comb begin
		marker = CODE_W'(1) << {dinfo.depth, 1'b0};
		code   = (inter & (marker - CODE_W'(1))) | marker;
	end

endmodule
